// ===== rtl/pr_pkg.sv =====
// Package for the page replacement unit: frame geometry, the sweep record
// that travels along the row of frame cells, state and register codes.
// No dependencies.
package pr_pkg;

  localparam int unsigned FRAMES     = 16;
  localparam int unsigned PAGE_BITS  = 16;
  localparam int unsigned SLOT_BITS  = 4;
  localparam int unsigned STAMP_BITS = 32;
  localparam int unsigned COUNT_BITS = 5;

  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;

  // Register indexes on the configuration channel.
  localparam logic [3:0] CFG_FRAME_COUNT = 4'd0;
  localparam logic [3:0] CFG_POLICY_MODE = 4'd1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Running result of the lookup, handed from cell to cell.
  typedef struct packed {
    logic   valid;
    logic   found;
    slot_t  hit_slot;
    logic   empty_found;
    slot_t  empty_slot;
    stamp_t best_age;
    slot_t  best_slot;
  } pr_rec_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } pr_state_e;

endpackage

// ===== rtl/page_replacement_fifo_lru.sv =====
// Top level of the page replacement unit: control, counters, configuration
// registers and the row of frame cells. Depends on pr_pkg and pr_cell.
//
// Each page reference is a transaction on start_i while busy_o is low. The
// lookup record walks the row of frame cells one cell per cycle: a launch
// register, then the n active cells, n being the active frame count (1 to
// 16), then the registered commit to the outputs. The result appears for
// exactly one cycle on result_valid_o; the receiver cannot stall it, and a
// new reference may be started in that same cycle. Configuration writes are
// always ready and should be made only while busy_o is low.
module page_replacement_fifo_lru (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] page_number_i,
  input  logic        start_string_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic        hit_o,
  output logic [3:0]  frame_index_o,
  output logic        evicted_valid_o,
  output logic [15:0] evicted_page_o,
  output logic [31:0] fault_total_o
);

  localparam int unsigned F = pr_pkg::FRAMES;

  pr_pkg::pr_state_e state_q, state_d;
  logic              accept, commit, launch_q;
  logic [4:0]        frame_count_q;
  logic              policy_q;
  pr_pkg::slot_t     last_q;
  pr_pkg::page_t     page_q;
  pr_pkg::stamp_t    clock_q;
  logic [31:0]       fault_q, fault_d;

  pr_pkg::pr_rec_t   rec_in  [F];
  pr_pkg::pr_rec_t   rec_out [F];
  pr_pkg::page_t     cell_page [F];
  logic [F-1:0]      cell_we;
  pr_pkg::pr_rec_t   seed, fin;
  pr_pkg::slot_t     slot;
  logic              evict, cell_clear, write_frame;
  pr_pkg::slot_t     last_d;

  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign cell_clear  = accept && start_string_i;

  // Index of the last active frame; a count of zero acts as one.
  always_comb begin
    if (frame_count_q == '0) begin
      last_d = '0;
    end else if (frame_count_q > pr_pkg::COUNT_BITS'(F)) begin
      last_d = pr_pkg::SLOT_BITS'(F - 1);
    end else begin
      last_d = pr_pkg::SLOT_BITS'(frame_count_q - 5'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= 5'd4;
      policy_q      <= pr_pkg::POLICY_FIFO;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pr_pkg::CFG_FRAME_COUNT: frame_count_q <= cfg_data_i;
        pr_pkg::CFG_POLICY_MODE: policy_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sweep seed: nothing found yet, frame 0 as the provisional victim.
  always_comb begin
    seed       = '0;
    seed.valid = launch_q;
  end

  assign fin    = rec_out[last_q];
  assign commit = (state_q == pr_pkg::ST_SWEEP) && fin.valid;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pr_pkg::ST_IDLE:  if (accept) state_d = pr_pkg::ST_SWEEP;
      pr_pkg::ST_SWEEP: if (commit) state_d = pr_pkg::ST_IDLE;
      default:          state_d = pr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != pr_pkg::ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pr_pkg::ST_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= accept;
    end
  end

  always_comb begin
    evict = !fin.found && !fin.empty_found;
    if (fin.found) begin
      slot = fin.hit_slot;
    end else if (fin.empty_found) begin
      slot = fin.empty_slot;
    end else begin
      slot = fin.best_slot;
    end
    // A hit restamps the frame only under the least recently used policy.
    write_frame = commit && (!fin.found || (policy_q == pr_pkg::POLICY_LRU));
    fault_d     = fault_q;
    if (!fin.found && (fault_q != '1)) begin
      fault_d = fault_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= '0;
      fault_q <= '0;
    end else if (accept) begin
      clock_q <= (start_string_i ? '0 : clock_q) + pr_pkg::STAMP_BITS'(1);
      if (start_string_i) begin
        fault_q <= '0;
      end
    end else if (commit) begin
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= page_number_i[pr_pkg::PAGE_BITS-1:0];
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_o           <= fin.found;
      frame_index_o   <= slot;
      evicted_valid_o <= evict;
      evicted_page_o  <= evict ? 16'(cell_page[slot]) : '0;
      fault_total_o   <= fault_d;
    end
  end

  for (genvar i = 0; i < F; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign rec_in[i] = seed;
    end else begin : g_link
      // The record stops at the last active frame, so it cannot come back
      // round as a stale commit when a later sweep covers more frames. The
      // valid flag is the top bit of the record.
      assign rec_in[i] = {rec_out[i-1].valid && (last_q != pr_pkg::SLOT_BITS'(i-1)),
                          rec_out[i-1][$bits(pr_pkg::pr_rec_t)-2:0]};
    end
    assign cell_we[i] = write_frame && (slot == pr_pkg::SLOT_BITS'(i));

    pr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (pr_pkg::SLOT_BITS'(i)),
      .clear_i    (cell_clear),
      .we_i       (cell_we[i]),
      .wpage_i    (page_q),
      .wstamp_i   (clock_q),
      .page_i     (page_q),
      .clock_i    (clock_q),
      .rec_i      (rec_in[i]),
      .rec_o      (rec_out[i]),
      .page_o     (cell_page[i])
    );
  end

  // The sweep passes the launch register and at least one cell, so strobes never touch.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o && !result_valid_o)
    else $error("accepted reference did not start a sweep");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> !evicted_valid_o)
    else $error("eviction reported on a hit");

  a_commit_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> $onehot0(cell_we))
    else $error("more than one frame written at commit");

endmodule

// ===== rtl/pr_cell.sv =====
// One page frame of the replacement unit: page, valid bit and use stamp,
// plus one stage of the lookup sweep. Depends on pr_pkg.
module pr_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pr_pkg::slot_t   cell_idx_i,
  input  logic            clear_i,
  input  logic            we_i,
  input  pr_pkg::page_t   wpage_i,
  input  pr_pkg::stamp_t  wstamp_i,
  input  pr_pkg::page_t   page_i,
  input  pr_pkg::stamp_t  clock_i,
  input  pr_pkg::pr_rec_t rec_i,
  output pr_pkg::pr_rec_t rec_o,
  output pr_pkg::page_t   page_o
);

  pr_pkg::page_t   page_q;
  logic            valid_q;
  pr_pkg::stamp_t  stamp_q;
  pr_pkg::pr_rec_t rec_d, rec_q;
  pr_pkg::stamp_t  age;
  logic            match;

  assign match = valid_q && (page_q == page_i);
  // The subtraction wraps, so ages stay right across a clock wrap.
  assign age   = clock_i - stamp_q;

  always_comb begin
    rec_d = rec_i;
    if (!rec_i.found && match) begin
      rec_d.found    = 1'b1;
      rec_d.hit_slot = cell_idx_i;
    end
    if (!rec_i.empty_found && !valid_q) begin
      rec_d.empty_found = 1'b1;
      rec_d.empty_slot  = cell_idx_i;
    end
    // Strictly greater, so a tie stays with the lower index.
    if (age > rec_i.best_age) begin
      rec_d.best_age  = age;
      rec_d.best_slot = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      stamp_q <= '0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
      stamp_q <= '0;
    end else if (we_i) begin
      valid_q <= 1'b1;
      stamp_q <= wstamp_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && !clear_i) begin
      page_q <= wpage_i;
    end
  end

  assign rec_o  = rec_q;
  assign page_o = page_q;

endmodule
